### design/dnle_pkg.sv
// Package for the DNS name label encoder.
// Holds the sizing constants, the status codes and the queue entry type.
// No dependencies.
package dnle_pkg;

    localparam int MAX_NAME_BYTES = 256;
    localparam int POS_W          = $clog2(MAX_NAME_BYTES + 2);
    localparam int CNT_W          = 6;
    localparam int LABEL_MAX      = 63;
    localparam int QDEPTH         = 4;
    localparam int QPTR_W         = $clog2(QDEPTH);
    localparam int QCNT_W         = $clog2(QDEPTH + 1);

    localparam logic [7:0] DOT_CHAR = 8'h2E;
    localparam logic [7:0] END_CHAR = 8'h00;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_LABEL_LONG = 2'd1,
        ST_OVERFLOW   = 2'd2
    } t_status;

    // One queue entry: an optional data write followed by an optional root write.
    typedef struct packed {
        logic       has_data;
        logic [7:0] data_byte;
        logic [7:0] data_off;
        logic       has_root;
        logic [7:0] root_off;
        t_status    status;
        logic [8:0] enc_len;
    } t_cmd;

endpackage

### design/dnle_front.sv
// Front end of the DNS name label encoder: accepts characters and tracks labels.
// Produces one queue entry per character that causes writes. Uses dnle_pkg.
module dnle_front
    import dnle_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_ch,
    input  logic       i_room,
    output logic       o_ready,
    output logic       o_push,
    output t_cmd       o_cmd
);

    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_NAME_BYTES);
    localparam logic [POS_W-1:0] POS_CAP = POS_W'(MAX_NAME_BYTES + 1);

    logic [POS_W-1:0] r_label_start, n_label_start;
    logic [POS_W-1:0] r_wr_pos, n_wr_pos;
    logic [CNT_W-1:0] r_label_count, n_label_count;
    t_status          r_err, n_err;

    logic             accept;

    function automatic logic [POS_W-1:0] pos_next(input logic [POS_W-1:0] p);
        pos_next = (p < POS_CAP) ? p + POS_W'(1) : POS_CAP;
    endfunction

    assign accept  = i_valid && i_room;
    assign o_ready = i_room;

    always_comb begin
        logic             data_req;
        logic [POS_W-1:0] data_pos;
        logic [POS_W-1:0] root;
        logic [POS_W:0]   len;
        t_status          err;

        n_label_start = r_label_start;
        n_wr_pos      = r_wr_pos;
        n_label_count = r_label_count;
        err           = r_err;
        data_req      = 1'b0;
        data_pos      = r_wr_pos;
        root          = r_label_start;
        len           = '0;
        o_cmd         = '0;
        o_cmd.status  = ST_OK;

        if (i_ch == END_CHAR) begin
            data_req        = (r_label_count != '0);
            data_pos        = r_label_start;
            o_cmd.data_byte = 8'(r_label_count);
        end else if (i_ch == DOT_CHAR) begin
            data_req        = 1'b1;
            data_pos        = r_label_start;
            o_cmd.data_byte = 8'(r_label_count);
            n_label_start   = r_wr_pos;
            n_wr_pos        = pos_next(r_wr_pos);
            n_label_count   = '0;
        end else begin
            if (r_label_count == CNT_W'(LABEL_MAX)) begin
                if (err == ST_OK) begin
                    err = ST_LABEL_LONG;
                end
            end else begin
                n_label_count = r_label_count + CNT_W'(1);
            end
            data_req        = 1'b1;
            data_pos        = r_wr_pos;
            o_cmd.data_byte = i_ch;
            n_wr_pos        = pos_next(r_wr_pos);
        end

        if (data_req && data_pos >= MAX_POS && err == ST_OK) begin
            err = ST_OVERFLOW;
        end
        o_cmd.has_data = data_req && (data_pos < MAX_POS);
        o_cmd.data_off = 8'(data_pos);

        if (i_ch == END_CHAR) begin
            root = data_req ? r_wr_pos : r_label_start;
            if (root >= MAX_POS) begin
                if (err == ST_OK) begin
                    err = ST_OVERFLOW;
                end
                root = MAX_POS - POS_W'(1);
            end
            len            = {1'b0, root} + (POS_W + 1)'(1);
            o_cmd.has_root = 1'b1;
            o_cmd.root_off = 8'(root);
            o_cmd.status   = err;
            o_cmd.enc_len  = 9'(len);
            n_label_start  = '0;
            n_wr_pos       = POS_W'(1);
            n_label_count  = '0;
            err            = ST_OK;
        end
        n_err = err;
    end

    assign o_push = accept && (o_cmd.has_data || o_cmd.has_root);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_label_start <= '0;
            r_wr_pos      <= POS_W'(1);
            r_label_count <= '0;
            r_err         <= ST_OK;
        end else if (accept) begin
            r_label_start <= n_label_start;
            r_wr_pos      <= n_wr_pos;
            r_label_count <= n_label_count;
            r_err         <= n_err;
        end
    end

endmodule

### design/dnle_queue.sv
// Short queue between the front and back ends of the DNS name label encoder.
// Holds pending write entries. Uses dnle_pkg.
module dnle_queue
    import dnle_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_room,
    output logic o_valid,
    output t_cmd o_head
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_room  = (r_count < QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

### design/dnle_back.sv
// Back end of the DNS name label encoder: turns queue entries into output beats.
// Drives the registered output stage. Uses dnle_pkg.
module dnle_back
    import dnle_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_cmd        i_head,
    input  logic        i_out_ready,
    output logic        o_pop,
    output logic        o_out_valid,
    output logic [31:0] o_out_data,
    output logic        o_out_last
);

    logic       r_phase, n_phase;
    logic       r_valid;
    logic [7:0] r_byte, n_byte;
    logic [7:0] r_off, n_off;
    logic       r_last, n_last;
    t_status    r_status, n_status;
    logic [8:0] r_len, n_len;
    logic       load;

    assign load = i_valid && (!r_valid || i_out_ready);

    always_comb begin
        n_phase  = r_phase;
        o_pop    = 1'b0;
        n_byte   = i_head.data_byte;
        n_off    = i_head.data_off;
        n_last   = 1'b0;
        n_status = ST_OK;
        n_len    = '0;
        if (i_head.has_data && !r_phase) begin
            if (i_head.has_root) begin
                n_phase = 1'b1;
            end else begin
                o_pop = load;
            end
        end else begin
            n_byte   = '0;
            n_off    = i_head.root_off;
            n_last   = 1'b1;
            n_status = i_head.status;
            n_len    = i_head.enc_len;
            n_phase  = 1'b0;
            o_pop    = load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_phase <= n_phase;
                r_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte   <= n_byte;
            r_off    <= n_off;
            r_last   <= n_last;
            r_status <= n_status;
            r_len    <= n_len;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_last  = r_last;
    assign o_out_data  = {5'b0, r_len, r_status, r_off, r_byte};

endmodule

### design/dns_name_label_encoder.sv
// Top level of the DNS name label encoder.
// Instantiates dnle_front, dnle_queue and dnle_back. Uses dnle_pkg.
//
// The block takes one hostname character per cycle while its queue has room and turns it
// into byte writes of the length-prefixed label form, each tagged with its offset in the
// encoded name. A terminator that closes a non-empty label yields two beats, and the
// output register issues one beat per cycle while m_axis_tready is high; the four-entry
// queue between the front and back ends absorbs the extra beat unless such names follow
// each other closely, in which case the input stalls. A character's beat passes through
// the queue and then the output register before it can be taken. The status and total
// length are valid on the beat that carries tlast.
module dns_name_label_encoder
    import dnle_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] ch
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] out_byte, [15:8] offset, [17:16] status,
                                        // [26:18] encoded length, [31:27] zero
    output logic        m_axis_tlast
);

    logic room;
    logic push;
    logic pop;
    logic head_valid;
    t_cmd cmd;
    t_cmd head;

    dnle_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_ch    (s_axis_tdata),
        .i_room  (room),
        .o_ready (s_axis_tready),
        .o_push  (push),
        .o_cmd   (cmd)
    );

    dnle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_room  (room),
        .o_valid (head_valid),
        .o_head  (head)
    );

    dnle_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (head_valid),
        .i_head      (head),
        .i_out_ready (m_axis_tready),
        .o_pop       (pop),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output beat present straight after reset");

    a_data_beat_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[31:16] == 16'd0)
        else $error("status or length set on a data beat");

    a_root_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |->
            m_axis_tdata[7:0] == 8'd0 &&
            m_axis_tdata[25:18] == 8'(m_axis_tdata[15:8] + 8'd1))
        else $error("root beat length does not follow its offset");

endmodule
